/* sv/svpwm_duty_and_sample_point_top_defines.svh */
// Assertion macros for the SVPWM duty and sample point block.
`ifndef SVPWM_DUTY_AND_SAMPLE_POINT_TOP_DEFINES_SVH
`define SVPWM_DUTY_AND_SAMPLE_POINT_TOP_DEFINES_SVH

// antecedent implies consequent, checked out of reset
`define SVPWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("svpwm check failed");

// condition implies that prev held earlier, the given depth back
`define SVPWM_ASSERT_PAST(label, cond, prev, depth) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> $past(prev, depth)) \
    else $error("svpwm check failed");

`endif

/* sv/svpwm_pkg.sv */
// Shared types, constants and tables of the SVPWM duty and sample point block.
package svpwm_pkg;

  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CODE_W    = 3;
  localparam int SB_W      = 34;
  localparam int MAG_W     = 36;
  localparam int HALF_W    = 18;
  localparam int PP_W      = 34;
  localparam int DIV_W     = 38;
  localparam int REM_W     = 54;
  localparam int DIV_STEPS = 15;
  localparam int BUS_SHIFT = 17;
  localparam int LATENCY   = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd3;

  localparam logic [DATA_W-1:0] PERIOD_RST = 16'd8400;
  localparam logic [DATA_W-1:0] TOP_RST    = 16'd4200;
  localparam logic [DATA_W-1:0] SETTLE_RST = 16'd200;
  localparam logic [DATA_W-1:0] OFFSET_RST = 16'd100;

  localparam logic signed [SB_W-1:0] SQRT3_Q16 = 34'sd113512;

  localparam logic [CODE_W-1:0] CODE_ZERO = 3'd0;
  localparam logic [CODE_W-1:0] SEC_1     = 3'd1;
  localparam logic [CODE_W-1:0] SEC_2     = 3'd2;
  localparam logic [CODE_W-1:0] SEC_3     = 3'd3;
  localparam logic [CODE_W-1:0] SEC_4     = 3'd4;
  localparam logic [CODE_W-1:0] SEC_5     = 3'd5;
  localparam logic [CODE_W-1:0] SEC_6     = 3'd6;
  localparam logic [CODE_W-1:0] CODE_FULL = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] settle;
    logic [DATA_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] alpha_voltage;
    logic signed [DATA_W-1:0] beta_voltage;
    logic [DATA_W-1:0]        bus_voltage;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] compare_a;
    logic [DATA_W-1:0] compare_b;
    logic [DATA_W-1:0] compare_c;
    logic [DATA_W-1:0] sample_point;
    logic              sample_mirrored;
    logic [CODE_W-1:0] sector_code;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] sect;
    logic [MAG_W-1:0]  e;
    logic [MAG_W-1:0]  r;
    logic [MAG_W-1:0]  ma;
    logic [MAG_W-1:0]  mb;
  } vec_t;

  typedef struct packed {
    logic                   valid;
    logic [CODE_W-1:0]      code;
    logic [CODE_W-1:0]      sect;
    logic [DIV_W-1:0]       div;
    logic [2:0][REM_W-1:0]  num;
  } num_t;

  typedef struct packed {
    logic                   valid;
    logic [CODE_W-1:0]      code;
    logic [CODE_W-1:0]      sect;
    logic [2:0][DATA_W-1:0] cmp;
  } cmp_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // value index (v1..v3) per phase: {c, b, a}
  function automatic logic [5:0] phase_sel(input logic [CODE_W-1:0] s);
    logic [5:0] r;
    case (s)
      SEC_1:   r = {2'd2, 2'd0, 2'd1};
      SEC_2:   r = {2'd1, 2'd2, 2'd0};
      SEC_3:   r = {2'd2, 2'd1, 2'd0};
      SEC_4:   r = {2'd0, 2'd1, 2'd2};
      SEC_5:   r = {2'd1, 2'd0, 2'd2};
      SEC_6:   r = {2'd0, 2'd2, 2'd1};
      default: r = {2'd2, 2'd1, 2'd0};
    endcase
    return r;
  endfunction

  // reference and other phase: {other, ref}
  function automatic logic [3:0] ref_sel(input logic [CODE_W-1:0] s);
    logic [3:0] r;
    case (s)
      SEC_1:   r = {2'd1, 2'd0};
      SEC_2:   r = {2'd0, 2'd1};
      SEC_3:   r = {2'd2, 2'd1};
      SEC_4:   r = {2'd1, 2'd2};
      SEC_5:   r = {2'd0, 2'd2};
      SEC_6:   r = {2'd2, 2'd0};
      default: r = {2'd2, 2'd1};
    endcase
    return r;
  endfunction

endpackage

/* sv/svpwm_duty_and_sample_point_top.sv */
// Top level of the SVPWM duty and sample point block.
//
// Usage:
//   Input items (alpha, beta, bus voltage) are taken at a rising edge with
//   start high and busy low. busy is high only during reset, so an item may
//   be given in every cycle.
//   Each result is shown for one cycle with done high; results leave in
//   item order, one per item. Throughput is one item per cycle. The
//   latency is set by the 15-stage restoring divider that forms the three
//   compare values, plus eight stages of sector decode, period products and
//   sample point selection. The receiver has no back-pressure: done cannot
//   be held off. Registers must be written through cfg_wr_en / cfg_index /
//   cfg_data only while no item is in flight; the block does not enforce
//   this. They take effect for items taken afterwards. Reset clears all
//   items in flight and loads the register defaults.
module svpwm_duty_and_sample_point_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  svpwm_pkg::in_item_t                  in_item,
  output logic                                 done,
  output svpwm_pkg::out_item_t                 result,
  input  logic                                 cfg_wr_en,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [svpwm_pkg::DATA_W-1:0]         cfg_data
);
  import svpwm_pkg::*;

  cfg_t cfg;
  vec_t vec;
  num_t num;
  cmp_t cmp;
  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period <= PERIOD_RST;
      cfg.top    <= TOP_RST;
      cfg.settle <= SETTLE_RST;
      cfg.offset <= OFFSET_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PERIOD: cfg.period <= cfg_data;
        CFG_TOP:    cfg.top    <= cfg_data;
        CFG_SETTLE: cfg.settle <= cfg_data;
        CFG_OFFSET: cfg.offset <= cfg_data;
        default:    cfg.period <= cfg.period;
      endcase
    end
  end

  svpwm_vec u_vec (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_item  (in_item),
    .vec      (vec)
  );

  svpwm_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .period (cfg.period),
    .vec    (vec),
    .num    (num)
  );

  svpwm_div u_div (
    .clk (clk),
    .rst (rst),
    .num (num),
    .cmp (cmp)
  );

  svpwm_samp u_samp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmp    (cmp),
    .done   (done),
    .result (result)
  );

endmodule

/* sv/svpwm_vec.sv */
// Sector decode, active vector magnitudes and saturation scale (three stages).
module svpwm_vec (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  svpwm_pkg::in_item_t in_item,
  output svpwm_pkg::vec_t     vec
);
  import svpwm_pkg::*;

  logic signed [SB_W-1:0]  b_ext;
  logic signed [MAG_W-1:0] a_ext;

  logic                    v1;
  logic signed [SB_W-1:0]  sb;
  logic signed [MAG_W-1:0] a3;
  logic                    bpos;
  logic [DATA_W-1:0]       udc;

  logic signed [MAG_W-1:0] sb_x, av, bv, cv;
  logic [CODE_W-1:0]       code_c, sect_c;
  logic [MAG_W-1:0]        ma_c, mb_c;

  logic                    v2;
  logic [CODE_W-1:0]       code2, sect2;
  logic [MAG_W-1:0]        ma2, mb2, d2;

  logic [MAG_W-1:0]        sum3, e3;

  assign b_ext = SB_W'($signed(in_item.beta_voltage));
  assign a_ext = MAG_W'($signed(in_item.alpha_voltage));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    sb   <= b_ext * SQRT3_Q16;
    a3   <= (a_ext <<< 17) + (a_ext <<< 16);
    bpos <= !in_item.beta_voltage[DATA_W-1] && (in_item.beta_voltage != '0);
    udc  <= in_item.bus_voltage;
  end

  always_comb begin
    sb_x   = MAG_W'(sb);
    av     = sb_x <<< 1;
    bv     = a3 - sb_x;
    cv     = -a3 - sb_x;
    code_c = {!cv[MAG_W-1] && (cv != '0), !bv[MAG_W-1] && (bv != '0), bpos};
    case (code_c)
      SEC_3: begin
        ma_c = mag(bv);
        mb_c = mag(av);
      end
      SEC_1: begin
        ma_c = mag(bv);
        mb_c = mag(cv);
      end
      SEC_5: begin
        ma_c = mag(av);
        mb_c = mag(cv);
      end
      SEC_4: begin
        ma_c = mag(av);
        mb_c = mag(bv);
      end
      SEC_6: begin
        ma_c = mag(cv);
        mb_c = mag(bv);
      end
      SEC_2: begin
        ma_c = mag(cv);
        mb_c = mag(av);
      end
      default: begin
        ma_c = '0;
        mb_c = '0;
      end
    endcase
    sect_c = (code_c == CODE_ZERO || code_c == CODE_FULL) ? SEC_3 : code_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    code2 <= code_c;
    sect2 <= sect_c;
    ma2   <= ma_c;
    mb2   <= mb_c;
    d2    <= MAG_W'(udc) << BUS_SHIFT;
  end

  always_comb begin
    sum3 = ma2 + mb2;
    e3   = (sum3 > d2) ? sum3 : d2;
    if (e3 == '0) begin
      e3 = MAG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec.valid <= 1'b0;
    end else begin
      vec.valid <= v2;
    end
    vec.code <= code2;
    vec.sect <= sect2;
    vec.e    <= e3;
    vec.r    <= e3 - sum3;
    vec.ma   <= ma2;
    vec.mb   <= mb2;
  end

endmodule

/* sv/svpwm_mul.sv */
// Period products and compare numerators (three stages).
module svpwm_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic [svpwm_pkg::DATA_W-1:0] period,
  input  svpwm_pkg::vec_t     vec,
  output svpwm_pkg::num_t     num
);
  import svpwm_pkg::*;

  logic              v4;
  logic [CODE_W-1:0] code4, sect4;
  logic [DIV_W-1:0]  dv4;
  logic [PP_W-1:0]   pr_lo, pr_hi, pa_lo, pa_hi, pb_lo, pb_hi;

  logic              v5;
  logic [CODE_W-1:0] code5, sect5;
  logic [DIV_W-1:0]  dv5;
  logic [REM_W-1:0]  pr, pa, pb;

  logic [2:0][REM_W-1:0] n;
  logic [5:0]            sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= vec.valid;
    end
    code4 <= vec.code;
    sect4 <= vec.sect;
    dv4   <= DIV_W'(vec.e) << 2;
    pr_lo <= PP_W'(period) * PP_W'(vec.r[HALF_W-1:0]);
    pr_hi <= PP_W'(period) * PP_W'(vec.r[MAG_W-1:HALF_W]);
    pa_lo <= PP_W'(period) * PP_W'(vec.ma[HALF_W-1:0]);
    pa_hi <= PP_W'(period) * PP_W'(vec.ma[MAG_W-1:HALF_W]);
    pb_lo <= PP_W'(period) * PP_W'(vec.mb[HALF_W-1:0]);
    pb_hi <= PP_W'(period) * PP_W'(vec.mb[MAG_W-1:HALF_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    code5 <= code4;
    sect5 <= sect4;
    dv5   <= dv4;
    pr    <= REM_W'(pr_lo) + (REM_W'(pr_hi) << HALF_W);
    pa    <= REM_W'(pa_lo) + (REM_W'(pa_hi) << HALF_W);
    pb    <= REM_W'(pb_lo) + (REM_W'(pb_hi) << HALF_W);
  end

  always_comb begin
    n[0] = pr;
    n[1] = pr + (pa << 1);
    n[2] = n[1] + (pb << 1);
    sel  = phase_sel(sect5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num.valid <= 1'b0;
    end else begin
      num.valid <= v5;
    end
    num.code   <= code5;
    num.sect   <= sect5;
    num.div    <= dv5;
    num.num[0] <= n[sel[1:0]];
    num.num[1] <= n[sel[3:2]];
    num.num[2] <= n[sel[5:4]];
  end

endmodule

/* sv/svpwm_div.sv */
// Three-lane restoring divider, one quotient bit per stage.
module svpwm_div (
  input  logic            clk,
  input  logic            rst,
  input  svpwm_pkg::num_t num,
  output svpwm_pkg::cmp_t cmp
);
  import svpwm_pkg::*;

  logic [DIV_STEPS-1:0]    sv;
  logic [CODE_W-1:0]       sc [DIV_STEPS];
  logic [CODE_W-1:0]       ss [DIV_STEPS];
  logic [DIV_W-1:0]        sd [DIV_STEPS];
  logic [2:0][REM_W-1:0]   srem [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] sq [DIV_STEPS];
  logic [2:0][REM_W-1:0]   nrem [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] nq [DIV_STEPS];

  always_comb begin
    logic [2:0][REM_W-1:0]     prem;
    logic [2:0][DIV_STEPS-1:0] pq;
    logic [DIV_W-1:0]          pd;
    logic [REM_W-1:0]          dsh;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        prem = num.num;
        pq   = '0;
        pd   = num.div;
      end else begin
        prem = srem[k-1];
        pq   = sq[k-1];
        pd   = sd[k-1];
      end
      dsh = REM_W'(pd) << (DIV_STEPS - 1 - k);
      for (int l = 0; l < 3; l++) begin
        if (prem[l] >= dsh) begin
          nrem[k][l] = prem[l] - dsh;
          nq[k][l]   = {pq[l][DIV_STEPS-2:0], 1'b1};
        end else begin
          nrem[k][l] = prem[l];
          nq[k][l]   = {pq[l][DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      sv <= {sv[DIV_STEPS-2:0], num.valid};
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      srem[k] <= nrem[k];
      sq[k]   <= nq[k];
      if (k == 0) begin
        sd[k] <= num.div;
        sc[k] <= num.code;
        ss[k] <= num.sect;
      end else begin
        sd[k] <= sd[k-1];
        sc[k] <= sc[k-1];
        ss[k] <= ss[k-1];
      end
    end
  end

  always_comb begin
    cmp.valid = sv[DIV_STEPS-1];
    cmp.code  = sc[DIV_STEPS-1];
    cmp.sect  = ss[DIV_STEPS-1];
    for (int l = 0; l < 3; l++) begin
      cmp.cmp[l] = DATA_W'(sq[DIV_STEPS-1][l]);
    end
  end

endmodule

/* sv/svpwm_samp.sv */
// Current sampling point selection, mirroring and clamp (two stages).
module svpwm_samp (
  input  logic                 clk,
  input  logic                 rst,
  input  svpwm_pkg::cfg_t      cfg,
  input  svpwm_pkg::cmp_t      cmp,
  output logic                 done,
  output svpwm_pkg::out_item_t result
);
  import svpwm_pkg::*;

  logic [3:0]              rsel;
  logic [DATA_W-1:0]       refv, oth, diff, delta;

  logic                    va;
  logic [CODE_W-1:0]       code_a;
  logic [2:0][DATA_W-1:0]  cmp_a;
  logic [DATA_W-1:0]       spm, spp;
  logic                    settle_gt, delta_gt;

  logic [DATA_W-1:0]       ceil_b, spmir, sp_b;
  logic                    mir_b;

  always_comb begin
    rsel  = ref_sel(cmp.sect);
    refv  = cmp.cmp[rsel[1:0]];
    oth   = cmp.cmp[rsel[3:2]];
    diff  = cfg.top - refv;
    delta = refv - oth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= cmp.valid;
    end
    code_a    <= cmp.code;
    cmp_a     <= cmp.cmp;
    spm       <= refv - cfg.offset;
    spp       <= refv + cfg.offset;
    settle_gt <= diff > cfg.settle;
    delta_gt  <= {1'b0, delta} > {diff, 1'b0};
  end

  always_comb begin
    ceil_b = cfg.top - DATA_W'(1);
    spmir  = cfg.top + cfg.top - spp - DATA_W'(1);
    mir_b  = 1'b0;
    if (settle_gt) begin
      sp_b = ceil_b;
    end else if (delta_gt) begin
      sp_b = spm;
    end else if (spp >= cfg.top) begin
      sp_b  = spmir;
      mir_b = 1'b1;
    end else begin
      sp_b = spp;
    end
    if (sp_b > ceil_b) begin
      sp_b = ceil_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= va;
    end
    result.compare_a       <= cmp_a[0];
    result.compare_b       <= cmp_a[1];
    result.compare_c       <= cmp_a[2];
    result.sample_point    <= sp_b;
    result.sample_mirrored <= mir_b;
    result.sector_code     <= code_a;
  end

endmodule

/* sv/svpwm_chk.sv */
// Port-level checks of the SVPWM duty and sample point block, bound to the top.
`include "svpwm_duty_and_sample_point_top_defines.svh"

module svpwm_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input svpwm_pkg::out_item_t result
);
  import svpwm_pkg::*;

  logic cmp_low;
  logic cmp_equal;
  logic zero_code;

  assign cmp_low   = !result.compare_a[DATA_W-1] && !result.compare_b[DATA_W-1] &&
                     !result.compare_c[DATA_W-1];
  assign cmp_equal = (result.compare_a == result.compare_b) &&
                     (result.compare_b == result.compare_c);
  assign zero_code = (result.sector_code == CODE_ZERO);

  `SVPWM_ASSERT_IMPL(a_item_done, start && !busy, ##LATENCY done)
  `SVPWM_ASSERT_PAST(a_done_item, done, start && !busy, LATENCY)
  `SVPWM_ASSERT_IMPL(a_cmp_range, done, cmp_low)
  `SVPWM_ASSERT_IMPL(a_zero_vec, done && zero_code, cmp_equal)

endmodule

bind svpwm_duty_and_sample_point_top svpwm_chk u_chk (.*);

/* verif/svpwm_duty_and_sample_point_top_tb.sv */
// Testbench for the SVPWM duty and sample point block: predicted results checked in order.
`timescale 1ns / 1ps

class svpwm_scoreboard;
  svpwm_pkg::out_item_t pending[$];
  logic [15:0] period = svpwm_pkg::PERIOD_RST;
  logic [15:0] top = svpwm_pkg::TOP_RST;
  logic [15:0] settle = svpwm_pkg::SETTLE_RST;
  logic [15:0] offset = svpwm_pkg::OFFSET_RST;
  int mismatches = 0;

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      svpwm_pkg::CFG_PERIOD: period = val;
      svpwm_pkg::CFG_TOP:    top = val;
      svpwm_pkg::CFG_SETTLE: settle = val;
      default:               offset = val;
    endcase
  endfunction

  function longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function void note_item(svpwm_pkg::in_item_t it);
    longint a, b, pa, pb, pc;
    longint unsigned ma, mb, e, p, n[3], c[3];
    logic [2:0] code, s;
    int sel[3];
    int rp, op;
    logic [15:0] r, o, diff, sp, ceil_v;
    logic [16:0] twice;
    logic mir;
    svpwm_pkg::out_item_t x;
    a = longint'(it.alpha_voltage);
    b = longint'(it.beta_voltage);
    pa = 2 * 113512 * b;
    pb = 3 * a * 65536 - 113512 * b;
    pc = -3 * a * 65536 - 113512 * b;
    code = {pc > 0, pb > 0, b > 0};
    case (code)
      svpwm_pkg::SEC_3: begin ma = abs64(pb); mb = abs64(pa); end
      svpwm_pkg::SEC_1: begin ma = abs64(pb); mb = abs64(pc); end
      svpwm_pkg::SEC_5: begin ma = abs64(pa); mb = abs64(pc); end
      svpwm_pkg::SEC_4: begin ma = abs64(pa); mb = abs64(pb); end
      svpwm_pkg::SEC_6: begin ma = abs64(pc); mb = abs64(pb); end
      svpwm_pkg::SEC_2: begin ma = abs64(pc); mb = abs64(pa); end
      default: begin ma = 0; mb = 0; end
    endcase
    s = (code == svpwm_pkg::CODE_ZERO || code == svpwm_pkg::CODE_FULL) ?
        svpwm_pkg::SEC_3 : code;
    case (s)
      svpwm_pkg::SEC_1: begin sel = '{1, 0, 2}; rp = 0; op = 1; end
      svpwm_pkg::SEC_2: begin sel = '{0, 2, 1}; rp = 1; op = 0; end
      svpwm_pkg::SEC_4: begin sel = '{2, 1, 0}; rp = 2; op = 1; end
      svpwm_pkg::SEC_5: begin sel = '{2, 0, 1}; rp = 2; op = 0; end
      svpwm_pkg::SEC_6: begin sel = '{1, 2, 0}; rp = 0; op = 2; end
      default:          begin sel = '{0, 1, 2}; rp = 1; op = 2; end
    endcase
    p = period;
    e = longint'(it.bus_voltage) * 131072;
    if (ma + mb > e) e = ma + mb;
    if (e == 0) e = 1;
    n[0] = p * (e - ma - mb);
    n[1] = n[0] + 2 * p * ma;
    n[2] = n[1] + 2 * p * mb;
    for (int i = 0; i < 3; i++) c[i] = n[sel[i]] / (4 * e);
    r = c[rp][15:0];
    o = c[op][15:0];
    mir = 1'b0;
    diff = top - r;
    if (diff > settle) sp = top - 16'd1;
    else begin
      twice = {diff, 1'b0};
      if ({1'b0, 16'(r - o)} > twice) sp = r - offset;
      else begin
        sp = r + offset;
        if (sp >= top) begin
          mir = 1'b1;
          sp = 16'(2 * 32'(top) - 32'(sp) - 1);
        end
      end
    end
    ceil_v = top - 16'd1;
    if (sp > ceil_v) sp = ceil_v;
    x.compare_a = c[0][15:0];
    x.compare_b = c[1][15:0];
    x.compare_c = c[2][15:0];
    x.sample_point = sp;
    x.sample_mirrored = mir;
    x.sector_code = code;
    pending.push_back(x);
  endfunction

  function void check_result(svpwm_pkg::out_item_t got);
    svpwm_pkg::out_item_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected a=%0d b=%0d c=%0d sp=%0d m=%0d code=%0d",
                 want.compare_a, want.compare_b, want.compare_c, want.sample_point,
                 want.sample_mirrored, want.sector_code);
        $display("          got      a=%0d b=%0d c=%0d sp=%0d m=%0d code=%0d",
                 got.compare_a, got.compare_b, got.compare_c, got.sample_point,
                 got.sample_mirrored, got.sector_code);
      end
    end
  endfunction
endclass

module svpwm_duty_and_sample_point_top_tb;
  import svpwm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic done;
  out_item_t result;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  svpwm_scoreboard board;

  svpwm_duty_and_sample_point_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(logic [15:0] al, logic [15:0] be, logic [15:0] bus);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{alpha_voltage: al, beta_voltage: be, bus_voltage: bus};
    do @(posedge clk); while (busy);
    board.note_item(in_item);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_items(int count);
    logic [15:0] al, be, bus;
    for (int i = 0; i < count; i++) begin
      al = 16'($urandom);
      be = 16'($urandom);
      case ($urandom_range(0, 3))
        0: bus = 16'($urandom);
        1: bus = 16'($urandom_range(1, 255));
        2: bus = 16'hffff;
        default: bus = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 40000));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        al = $signed(al) >>> $urandom_range(0, 15);
        be = $signed(be) >>> $urandom_range(0, 15);
      end
      send_item(al, be, bus);
    end
  endtask

  initial begin
    logic [15:0] edge_vals[6];
    board = new();
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h0100};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes, all sectors, zero vector, zero bus
    for (int i = 0; i < 6; i++)
      send_item(edge_vals[i], edge_vals[(i + 2) % 6], 16'd4000);
    send_item(16'h0000, 16'h0000, 16'h0000);
    send_item(16'h0000, 16'h0000, 16'hffff);
    send_item(16'h0500, 16'h0000, 16'h0000);
    send_item(16'h7fff, 16'h7fff, 16'h0001);
    send_item(16'h8000, 16'h8000, 16'hffff);
    for (int k = 0; k < 12; k++)
      send_item(16'($rtoi(1500.0 * $cos(k * 0.5236 + 0.2))),
                16'($rtoi(1500.0 * $sin(k * 0.5236 + 0.2))), 16'd3000);
    random_items(100);
    drain();
    write_reg(CFG_PERIOD, 16'hffff);
    write_reg(CFG_TOP, 16'd1);
    write_reg(CFG_SETTLE, 16'hffff);
    write_reg(CFG_OFFSET, 16'hffff);
    random_items(80);
    drain();
    write_reg(CFG_PERIOD, 16'd1);
    write_reg(CFG_TOP, 16'hffff);
    write_reg(CFG_SETTLE, 16'd0);
    write_reg(CFG_OFFSET, 16'd0);
    random_items(60);
    drain();
    write_reg(CFG_PERIOD, 16'd8400);
    write_reg(CFG_TOP, 16'd0);
    write_reg(CFG_SETTLE, 16'd65000);
    write_reg(CFG_OFFSET, 16'd300);
    random_items(60);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(CFG_PERIOD, 16'($urandom_range(1, 65535)));
      write_reg(CFG_TOP, 16'($urandom_range(1, 65535)));
      write_reg(CFG_SETTLE, 16'($urandom));
      write_reg(CFG_OFFSET, 16'($urandom_range(0, 2000)));
      random_items(35);
      drain();
    end
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/svpwm_pkg.sv
sv/svpwm_vec.sv
sv/svpwm_mul.sv
sv/svpwm_div.sv
sv/svpwm_samp.sv
sv/svpwm_duty_and_sample_point_top.sv
sv/svpwm_chk.sv
verif/svpwm_duty_and_sample_point_top_tb.sv
